// ----- design/four_level_page_table_walker_core_assert.svh -----
// Assertion macros for the page table walker checker.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define PTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ptw_pkg.sv -----
// Shared types and constants for the four-level page table walker.
// No dependencies; used by every module of the block.
package ptw_pkg;

  localparam int DATA_W           = 64;
  localparam int VA_W             = 48;
  localparam int PA_W             = 52;
  localparam int IDX_W            = 13;
  localparam int SLOT_W           = 9;
  localparam int SLOTS            = 512;
  localparam int ROOT_W           = 4;
  localparam int FRAME_NUM_W      = 40;
  localparam int TABLE_FRAMES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int PRESENT_BIT      = 0;
  localparam int HUGE_BIT         = 7;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XLATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_NOT_PRESENT = 2'd1,
    STS_OUTSIDE     = 2'd2,
    STS_WRITE_DONE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PG_4K = 2'd0,
    PG_2M = 2'd1,
    PG_1G = 2'd2
  } page_size_t;

  typedef enum logic [1:0] {
    LVL_TOP  = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } back_state_t;

  // One classified transaction in the queue
  typedef struct packed {
    op_t                op;
    logic               wr_ok;
    logic [IDX_W-1:0]   entry_index;
    logic [DATA_W-1:0]  entry_value;
    logic [VA_W-1:0]    virt_addr;
  } q_item_t;

  // Back-pressure view seen by the front end
  typedef struct packed {
    logic q_full;
    logic clearing;
  } front_status_t;

endpackage

// ----- design/ptw_front.sv -----
// Front end: accepts command transactions and classifies them for the queue.
// Depends on ptw_pkg.
module ptw_front #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF
) (
  input  logic                          start,
  input  logic                          op,
  input  logic [ptw_pkg::IDX_W-1:0]     entry_index,
  input  logic [ptw_pkg::DATA_W-1:0]    entry_value,
  input  logic [ptw_pkg::VA_W-1:0]      virt_addr,
  input  ptw_pkg::front_status_t        st,
  output logic                          busy,
  output logic                          push,
  output ptw_pkg::q_item_t              item
);

  localparam int DEPTH = TABLE_FRAMES * ptw_pkg::SLOTS;

  // Hold off while the store is being cleared or the queue is full
  assign busy = st.clearing | st.q_full;
  assign push = start & ~busy;

  // Classify: op decode and store range check for writes
  always_comb begin
    item.op          = ptw_pkg::op_t'(op);
    item.wr_ok       = (32'(entry_index) < 32'(DEPTH));
    item.entry_index = entry_index;
    item.entry_value = entry_value;
    item.virt_addr   = virt_addr;
  end

endmodule

// ----- design/ptw_queue.sv -----
// Short FIFO between the front end and the walker back end.
// Depends on ptw_pkg for the item type.
module ptw_queue #(
  parameter int DEPTH = ptw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ptw_pkg::q_item_t  item_in,
  input  logic              pop,
  output ptw_pkg::q_item_t  item_out,
  output logic              empty,
  output logic              full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptw_pkg::q_item_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign item_out = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

// ----- design/ptw_back.sv -----
// Back end: table store, clearing pass, entry writes and the four-level walk.
// Depends on ptw_pkg.
module ptw_back #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [ptw_pkg::ROOT_W-1:0]    cfg_data,
  input  logic                          q_valid,
  input  ptw_pkg::q_item_t              q_item,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          done,
  output logic [ptw_pkg::PA_W-1:0]      phys_addr,
  output logic [1:0]                    page_size,
  output logic [1:0]                    status
);

  localparam int FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int AW    = FW + ptw_pkg::SLOT_W;
  localparam int DEPTH = TABLE_FRAMES * ptw_pkg::SLOTS;

  // Nine index bits for a given level
  function automatic logic [ptw_pkg::SLOT_W-1:0] slot_of(
    input logic [ptw_pkg::VA_W-1:0] va,
    input ptw_pkg::level_t          lvl
  );
    logic [ptw_pkg::SLOT_W-1:0] s;
    unique case (lvl)
      ptw_pkg::LVL_TOP:  s = va[47:39];
      ptw_pkg::LVL_PDPT: s = va[38:30];
      ptw_pkg::LVL_PD:   s = va[29:21];
      ptw_pkg::LVL_PT:   s = va[20:12];
    endcase
    return s;
  endfunction

  // Registers
  ptw_pkg::back_state_t           state, state_next;
  logic [AW-1:0]                  clr_addr;
  ptw_pkg::level_t                lvl, lvl_next;
  logic [ptw_pkg::VA_W-1:0]       cur_va;
  logic [ptw_pkg::ROOT_W-1:0]     root_frame;
  logic [ptw_pkg::DATA_W-1:0]     mem [DEPTH];
  logic [ptw_pkg::DATA_W-1:0]     rdata;

  // Control and datapath signals
  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_addr;
  logic [ptw_pkg::DATA_W-1:0]     mem_wdata;
  logic                           va_load;
  logic                           res_load;
  logic [ptw_pkg::PA_W-1:0]       res_phys;
  ptw_pkg::page_size_t            res_size;
  ptw_pkg::status_t               res_status;

  // Entry decode
  logic [ptw_pkg::FRAME_NUM_W-1:0] next_frame;
  logic present, huge_1g, huge_2m, leaf_4k, frame_ok, walk_more, root_ok, clr_last;

  always_comb begin
    next_frame = rdata[51:12];
    present    = rdata[ptw_pkg::PRESENT_BIT];
    huge_1g    = (lvl == ptw_pkg::LVL_PDPT) && rdata[ptw_pkg::HUGE_BIT];
    huge_2m    = (lvl == ptw_pkg::LVL_PD) && rdata[ptw_pkg::HUGE_BIT];
    leaf_4k    = (lvl == ptw_pkg::LVL_PT);
    frame_ok   = (next_frame < ptw_pkg::FRAME_NUM_W'(TABLE_FRAMES));
    walk_more  = present && !huge_1g && !huge_2m && !leaf_4k && frame_ok;
    root_ok    = (32'(root_frame) < 32'(TABLE_FRAMES));
    clr_last   = (clr_addr == AW'(DEPTH - 1));
  end

  assign clearing = (state == ptw_pkg::ST_CLEAR);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptw_pkg::ST_CLEAR: begin
        if (clr_last) state_next = ptw_pkg::ST_IDLE;
      end
      ptw_pkg::ST_IDLE: begin
        if (q_valid && q_item.op == ptw_pkg::OP_XLATE && root_ok) begin
          state_next = ptw_pkg::ST_WALK;
        end
      end
      ptw_pkg::ST_WALK: begin
        if (!walk_more) state_next = ptw_pkg::ST_IDLE;
      end
      default: state_next = ptw_pkg::ST_IDLE;
    endcase
  end

  // Outputs: memory control and result load
  always_comb begin
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = clr_addr;
    mem_wdata  = '0;
    va_load    = 1'b0;
    lvl_next   = lvl;
    res_load   = 1'b0;
    res_phys   = '0;
    res_size   = ptw_pkg::PG_4K;
    res_status = ptw_pkg::STS_OK;
    unique case (state)
      ptw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ptw_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == ptw_pkg::OP_WRITE) begin
            mem_we     = q_item.wr_ok;
            mem_addr   = AW'(q_item.entry_index);
            mem_wdata  = q_item.entry_value;
            res_load   = 1'b1;
            res_status = ptw_pkg::STS_WRITE_DONE;
          end else begin
            va_load = 1'b1;
            if (root_ok) begin
              mem_re   = 1'b1;
              mem_addr = {FW'(root_frame), slot_of(q_item.virt_addr, ptw_pkg::LVL_TOP)};
              lvl_next = ptw_pkg::LVL_TOP;
            end else begin
              res_load   = 1'b1;
              res_status = ptw_pkg::STS_OUTSIDE;
            end
          end
        end
      end
      ptw_pkg::ST_WALK: begin
        priority if (!present) begin
          res_load   = 1'b1;
          res_status = ptw_pkg::STS_NOT_PRESENT;
        end else if (huge_1g) begin
          res_load = 1'b1;
          res_phys = {rdata[51:30], cur_va[29:0]};
          res_size = ptw_pkg::PG_1G;
        end else if (huge_2m) begin
          res_load = 1'b1;
          res_phys = {rdata[51:21], cur_va[20:0]};
          res_size = ptw_pkg::PG_2M;
        end else if (leaf_4k) begin
          res_load = 1'b1;
          res_phys = {rdata[51:12], cur_va[11:0]};
        end else if (!frame_ok) begin
          res_load   = 1'b1;
          res_status = ptw_pkg::STS_OUTSIDE;
        end else begin
          lvl_next = ptw_pkg::level_t'(lvl + 2'd1);
          mem_re   = 1'b1;
          mem_addr = {next_frame[FW-1:0], slot_of(cur_va, lvl_next)};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptw_pkg::ST_CLEAR;
      clr_addr   <= '0;
      root_frame <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (state == ptw_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_valid) root_frame <= cfg_data;
    end
  end

  // Walk context and result payload
  always_ff @(posedge clk) begin
    lvl <= lvl_next;
    if (va_load) cur_va <= q_item.virt_addr;
    if (res_load) begin
      phys_addr <= res_phys;
      page_size <= res_size;
      status    <= res_status;
    end
  end

  // Table store, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_addr];
  end

endmodule

// ----- design/four_level_page_table_walker_core.sv -----
// Channel   | Signals                                          | Handshake
// command   | start, op, entry_index, entry_value, virt_addr   | start & !busy
// result    | done, phys_addr, page_size, status               | done strobe, 1 cycle
// config    | cfg_valid, cfg_ready, cfg_data (root_frame)      | cfg_valid & cfg_ready
//
// A translation reads one entry per table level, up to four, from the single-port table
// store (none when the root frame lies outside it); done and the result follow in the
// cycle after a write or a walk ends. Results cannot be stalled.
// After rst the store is cleared one entry a cycle, TABLE_FRAMES * 512 entries (8192 at
// the default), with busy high throughout. A two-entry queue separates the command front
// end from the walker; after clearing, busy rises only when it is full.
// Depends on ptw_pkg, ptw_front, ptw_queue, ptw_back.
module four_level_page_table_walker_core #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF,
  parameter int QUEUE_DEPTH  = ptw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [ptw_pkg::IDX_W-1:0]     entry_index,
  input  logic [ptw_pkg::DATA_W-1:0]    entry_value,
  input  logic [ptw_pkg::VA_W-1:0]      virt_addr,
  output logic                          done,
  output logic [ptw_pkg::PA_W-1:0]      phys_addr,
  output logic [1:0]                    page_size,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptw_pkg::ROOT_W-1:0]    cfg_data
);

  ptw_pkg::front_status_t fst;
  ptw_pkg::q_item_t       push_item, pop_item;
  logic                   push, pop, q_empty, q_full, clearing;

  // Root register takes a write in any cycle
  assign cfg_ready = 1'b1;

  assign fst = '{q_full: q_full, clearing: clearing};

  ptw_front #(.TABLE_FRAMES(TABLE_FRAMES)) u_front (
    .start       (start),
    .op          (op),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .virt_addr   (virt_addr),
    .st          (fst),
    .busy        (busy),
    .push        (push),
    .item        (push_item)
  );

  ptw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (push_item),
    .pop      (pop),
    .item_out (pop_item),
    .empty    (q_empty),
    .full     (q_full)
  );

  ptw_back #(.TABLE_FRAMES(TABLE_FRAMES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (~q_empty),
    .q_item    (pop_item),
    .q_pop     (pop),
    .clearing  (clearing),
    .done      (done),
    .phys_addr (phys_addr),
    .page_size (page_size),
    .status    (status)
  );

endmodule

// ----- design/ptw_checker.sv -----
// Port-level checker for the page table walker, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_walker_core_assert.svh.
`include "four_level_page_table_walker_core_assert.svh"

module ptw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        busy,
  input logic                        done,
  input logic [ptw_pkg::PA_W-1:0]    phys_addr,
  input logic [1:0]                  page_size,
  input logic [1:0]                  status
);

  // Failed walks and writes report a zero address and 4 KiB size
  `PTW_ASSERT_SAME(a_fail_zero, done && status != ptw_pkg::STS_OK, phys_addr == '0 && page_size == ptw_pkg::PG_4K, "nonzero payload on a non-translated result")

  // A translated result carries a defined page size
  `PTW_ASSERT_SAME(a_size_legal, done && status == ptw_pkg::STS_OK, page_size != 2'd3, "illegal page size on a translated result")

  // Store clearing holds off commands right after reset
  `PTW_ASSERT_SAME(a_clear_busy, $fell(rst), busy, "commands accepted during the clearing pass")

  // No back-to-back result strobes right after reset is released
  `PTW_ASSERT_NEXT(a_no_done_in_reset, $past(rst) && !rst, !done || $past(done, 1) == 1'b0, "result right after reset")

endmodule

bind four_level_page_table_walker_core ptw_checker u_ptw_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .done      (done),
  .phys_addr (phys_addr),
  .page_size (page_size),
  .status    (status)
);
